// File: hw/rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned COUNT_W = 3;   // results per byte: 0..4

   localparam logic [CP_W-1:0] REPL_CHAR   = 21'h00FFFD;
   localparam logic [CP_W-1:0] MIN_CP_2    = 21'h000080;
   localparam logic [CP_W-1:0] MIN_CP_3    = 21'h000800;
   localparam logic [CP_W-1:0] MIN_CP_4    = 21'h010000;
   localparam logic [CP_W-1:0] MAX_CP      = 21'h10FFFF;

   // sequence lengths held in needed_ff
   localparam logic [2:0] SEQ_LEN_2 = 3'd2;
   localparam logic [2:0] SEQ_LEN_3 = 3'd3;
   localparam logic [2:0] SEQ_LEN_4 = 3'd4;

   // Burst of results caused by one byte: count-1 replacement words, then
   // the tail word. Only the tail may differ from a replacement.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [CP_W-1:0]    tail_cp;
      logic               tail_repl;
   } burst_type;

endpackage

`default_nettype wire

// File: hw/rtl/u8d_req_if.sv
// ----------------------------------------------------------------------------
// u8d_req_if
// Input channel: one text byte per word, with an end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8d_req_if;
   logic                       valid;
   logic                       ready;
   logic [u8d_pkg::BYTE_W-1:0] text_byte;
   logic                       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/u8d_rsp_if.sv
// ----------------------------------------------------------------------------
// u8d_rsp_if
// Result channel: one decoded code point per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8d_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [u8d_pkg::CP_W-1:0] code_point;
   logic                     was_replaced;
   logic                     last_of_run;

   modport source (output valid, output code_point, output was_replaced,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_point, input was_replaced,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/u8d_step.sv
// ----------------------------------------------------------------------------
// u8d_step
// Sequence state and the per-byte decode: gives the burst a byte causes and
// updates the pending sequence when the byte is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_step (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [u8d_pkg::BYTE_W-1:0] text_byte,
   input  wire logic                       end_of_text,
   output u8d_pkg::burst_type              burst
);
   import u8d_pkg::*;

   logic [CP_W-1:0] partial_ff, partial_in;
   logic [1:0]      held_ff, held_in;
   logic [2:0]      needed_ff, needed_in;

   logic            is_cont;
   logic [CP_W-1:0] grown;
   logic [2:0]      held_next;
   logic            bad;
   logic [2:0]      nrep;

   // decode one byte against the pending sequence
   always_comb begin
      is_cont   = (text_byte[7:6] == 2'b10);
      grown     = {partial_ff[CP_W-7:0], text_byte[5:0]};
      held_next = {1'b0, held_ff} + 3'd1;
      nrep      = {1'b0, held_ff};

      // range check of a completed sequence
      case (needed_ff)
         SEQ_LEN_2: bad = (grown < MIN_CP_2);
         SEQ_LEN_3: bad = (grown < MIN_CP_3);
         default:   bad = (grown < MIN_CP_4) || (grown > MAX_CP);
      endcase

      partial_in      = partial_ff;
      held_in         = held_ff;
      needed_in       = needed_ff;
      burst.count     = '0;
      burst.tail_cp   = REPL_CHAR;
      burst.tail_repl = 1'b1;

      if ((held_ff != 2'd0) && is_cont) begin
         if (held_next >= needed_ff) begin
            // sequence complete
            burst.count     = 3'd1;
            burst.tail_cp   = bad ? REPL_CHAR : grown;
            burst.tail_repl = bad;
            partial_in      = '0;
            held_in         = '0;
            needed_in       = '0;
         end else if (end_of_text) begin
            // cut off: one replacement per byte of the sequence, this byte included
            burst.count = held_next;
            partial_in  = '0;
            held_in     = '0;
            needed_in   = '0;
         end else begin
            partial_in = grown;
            held_in    = held_next[1:0];
         end
      end else begin
         // flush any broken sequence, then decode afresh
         partial_in = '0;
         held_in    = '0;
         needed_in  = '0;
         if (text_byte[7] == 1'b0) begin
            burst.count     = nrep + 3'd1;
            burst.tail_cp   = {{(CP_W-BYTE_W){1'b0}}, text_byte};
            burst.tail_repl = 1'b0;
         end else if ((text_byte[7:5] == 3'b110) || (text_byte[7:4] == 4'b1110)
                      || (text_byte[7:3] == 5'b11110)) begin
            if (end_of_text) begin
               burst.count = nrep + 3'd1;
            end else begin
               burst.count = nrep;
               held_in     = 2'd1;
               if (text_byte[7:5] == 3'b110) begin
                  partial_in = {{(CP_W-5){1'b0}}, text_byte[4:0]};
                  needed_in  = SEQ_LEN_2;
               end else if (text_byte[7:4] == 4'b1110) begin
                  partial_in = {{(CP_W-4){1'b0}}, text_byte[3:0]};
                  needed_in  = SEQ_LEN_3;
               end else begin
                  partial_in = {{(CP_W-3){1'b0}}, text_byte[2:0]};
                  needed_in  = SEQ_LEN_4;
               end
            end
         end else begin
            // lone continuation or invalid lead
            burst.count = nrep + 3'd1;
         end
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         held_ff    <= '0;
         needed_ff  <= '0;
      end else if (accept) begin
         partial_ff <= partial_in;
         held_ff    <= held_in;
         needed_ff  <= needed_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/u8d_emit.sv
// ----------------------------------------------------------------------------
// u8d_emit
// Result register: holds the burst of one byte and plays it out one word
// per handshake, replacements first and the tail word last.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_emit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire u8d_pkg::burst_type       burst,
   output logic                          space,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [u8d_pkg::CP_W-1:0]      code_point,
   output logic                          was_replaced,
   output logic                          last_of_run
);
   import u8d_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CP_W-1:0]    tail_cp_ff, tail_cp_in;
   logic               tail_repl_ff, tail_repl_in;
   logic               is_tail;

   assign is_tail   = (count_ff == 3'd1);
   assign rsp_valid = (count_ff != '0);
   // free now, or the final word leaves this cycle
   assign space     = (count_ff == '0) || (is_tail && rsp_ready);

   // output word
   always_comb begin
      last_of_run  = is_tail;
      code_point   = is_tail ? tail_cp_ff : REPL_CHAR;
      was_replaced = is_tail ? tail_repl_ff : 1'b1;
   end

   // burst count
   always_comb begin
      count_in     = count_ff;
      tail_cp_in   = tail_cp_ff;
      tail_repl_in = tail_repl_ff;
      if (load) begin
         count_in     = burst.count;
         tail_cp_in   = burst.tail_cp;
         tail_repl_in = burst.tail_repl;
      end else if (rsp_valid && rsp_ready) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_cp_ff   <= tail_cp_in;
      tail_repl_ff <= tail_repl_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// The first result of a byte is on the result port in the cycle after the
// byte is accepted. One byte per cycle is taken while each byte gives at
// most one result and the result port is ready; a byte giving more (up to
// four) holds the input while the single result register drains them.
// Reset (synchronous) clears the pending sequence and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_core (
   input  wire logic clock,
   input  wire logic reset,
   u8d_req_if.sink   req_chan,
   u8d_rsp_if.source rsp_chan
);
   import u8d_pkg::*;

   burst_type burst;
   logic      space;
   logic      accept;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   // decode against the pending sequence
   u8d_step u_step (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_chan.text_byte),
      .end_of_text (req_chan.end_of_text),
      .burst       (burst)
   );

   // result register
   u8d_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .burst        (burst),
      .space        (space),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .code_point   (rsp_chan.code_point),
      .was_replaced (rsp_chan.was_replaced),
      .last_of_run  (rsp_chan.last_of_run)
   );

endmodule

`default_nettype wire
